// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/cdstm_pkg.sv
// ----------------------------------------------------------------------------
// cdstm_pkg
// types, constants and decode helpers of the subcode time monitor
// ----------------------------------------------------------------------------
package cdstm_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [3:0]  AdrMode1        = 4'd1;
   localparam logic [7:0]  TrackLeadIn     = 8'h00;
   localparam logic [7:0]  TrackLeadOut    = 8'haa;
   localparam logic [7:0]  SecLast         = 8'd59;
   localparam logic [7:0]  StuckLimitReset = 8'd75;
   localparam logic [15:0] CntMax          = 16'hffff;

   // register index of stuck_limit
   localparam logic RegStuckLimit = 1'b0;

   typedef enum logic [2:0] {
      EvAdvance    = 3'd0,
      EvJump       = 3'd1,
      EvStuck      = 3'd2,
      EvRepeat     = 3'd3,
      EvSessionEnd = 3'd4
   } cdstm_event_type;

   // decoded q frame
   typedef struct packed {
      logic       good;     // crc ok and mode 1 adr
      logic       lead;     // lead-in or lead-out track code
      logic [7:0] track;
      logic [7:0] rel_min;
      logic [7:0] rel_sec;
      logic [7:0] abs_min;
      logic [7:0] abs_sec;
   } cdstm_frame_type;

   function automatic logic [3:0] rev4(input logic [3:0] v);
      return {v[0], v[1], v[2], v[3]};
   endfunction

   // high*10 + low, 0..165 for any pattern
   function automatic logic [7:0] bcd_decode(input logic [7:0] raw);
      return {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0} + {4'b0000, raw[3:0]};
   endfunction

endpackage

// File: rtl/cdstm_req_if.sv
// ----------------------------------------------------------------------------
// cdstm_req_if
// q frame channel: valid/ready with the raw 80-bit frame and crc flag
// ----------------------------------------------------------------------------
interface cdstm_req_if;
   logic        valid;
   logic        ready;
   logic        crc_ok;
   logic [31:0] q_word0;
   logic [31:0] q_word1;
   logic [15:0] q_word2_high;

   modport source (
      output valid, crc_ok, q_word0, q_word1, q_word2_high,
      input  ready
   );
   modport sink (
      input  valid, crc_ok, q_word0, q_word1, q_word2_high,
      output ready
   );
endinterface

// File: rtl/cdstm_rsp_if.sv
// ----------------------------------------------------------------------------
// cdstm_rsp_if
// result channel: valid/ready with event code, decoded times and counts
// ----------------------------------------------------------------------------
interface cdstm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  track;
   logic [7:0]  rel_min;
   logic [7:0]  rel_sec;
   logic [7:0]  prev_track;
   logic [7:0]  prev_min;
   logic [7:0]  prev_sec;
   logic [15:0] jump_count;
   logic [15:0] stuck_count;

   modport source (
      output valid, event_res, track, rel_min, rel_sec,
             prev_track, prev_min, prev_sec, jump_count, stuck_count,
      input  ready
   );
   modport sink (
      input  valid, event_res, track, rel_min, rel_sec,
             prev_track, prev_min, prev_sec, jump_count, stuck_count,
      output ready
   );
endinterface

// File: rtl/cdstm_decode.sv
// ----------------------------------------------------------------------------
// cdstm_decode
// q frame field decode: adr check, nibble reversal and bcd conversion
// ----------------------------------------------------------------------------
module cdstm_decode
   import cdstm_pkg::*;
(
   input  logic            crc_ok,
   input  logic [31:0]     q_word0,
   input  logic [31:0]     q_word1,
   input  logic [15:0]     q_word2_high,
   output cdstm_frame_type frame
);

   logic [7:0] raw_track;

   assign raw_track = {rev4(q_word0[23:20]), rev4(q_word0[19:16])};

   always_comb begin
      frame.good    = crc_ok && (rev4(q_word0[27:24]) == AdrMode1);
      frame.lead    = (raw_track == TrackLeadIn) || (raw_track == TrackLeadOut);
      frame.track   = bcd_decode(raw_track);
      frame.rel_min = bcd_decode({rev4(q_word0[7:4]), rev4(q_word0[3:0])});
      frame.rel_sec = bcd_decode({rev4(q_word1[31:28]), rev4(q_word1[27:24])});
      frame.abs_min = bcd_decode({rev4(q_word1[7:4]), rev4(q_word1[3:0])});
      frame.abs_sec = bcd_decode({rev4(q_word2_high[15:12]), rev4(q_word2_high[11:8])});
   end

endmodule

// File: rtl/cd_subcode_time_monitor.sv
// ----------------------------------------------------------------------------
// cd_subcode_time_monitor
// checks q subcode absolute time for jumps and stuck timestamps per session
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          beat contents
//  req      in         valid/ready        crc flag + 80-bit raw q frame
//  rsp      out        valid/ready        event code, decoded times, counts
//  csr      in         apb (psel/penable) stuck_limit at byte address 0
//
//  one beat per cycle sustained while rsp takes results; a taken frame goes
//  to the input register, then through decode/compare into the result register
//  session state is updated in the same edge that loads the result register
//  dropped frames (bad crc, wrong adr, lead frame outside a session) pass
//  the pipe without a result beat
//  a stalled rsp holds the result; req stays ready while the input
//  register can move on at the same edge
//  synchronous active-high reset clears control and session state,
//  stuck_limit returns to 75; req is not ready while reset is high
//
`include "assert_macros.svh"

module cd_subcode_time_monitor
   import cdstm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   cdstm_req_if.sink               req,
   cdstm_rsp_if.source             rsp,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   logic       csr_write;
   logic       csr_hit;
   logic [7:0] stuck_limit_ff;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == RegStuckLimit);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stuck_limit_ff <= StuckLimitReset;
      end else if (csr_write && csr_hit) begin
         stuck_limit_ff <= pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata[7:0] = stuck_limit_ff;
      end
   end

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic        s1_valid_ff;
   logic        s1_crc_ok_ff;
   logic [31:0] s1_q_word0_ff;
   logic [31:0] s1_q_word1_ff;
   logic [15:0] s1_q_word2_high_ff;
   logic        out_free;
   logic        advance;

   // result slot is empty or being drained this cycle
   assign out_free  = !rsp.valid || rsp.ready;
   assign advance   = s1_valid_ff && out_free;
   assign req.ready = !reset && (!s1_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_crc_ok_ff       <= req.crc_ok;
         s1_q_word0_ff      <= req.q_word0;
         s1_q_word1_ff      <= req.q_word1;
         s1_q_word2_high_ff <= req.q_word2_high;
      end
   end

   // ------------------------------------------------------------------
   // decode
   // ------------------------------------------------------------------
   cdstm_frame_type frame;

   cdstm_decode u_decode (
      .crc_ok       (s1_crc_ok_ff),
      .q_word0      (s1_q_word0_ff),
      .q_word1      (s1_q_word1_ff),
      .q_word2_high (s1_q_word2_high_ff),
      .frame        (frame)
   );

   // ------------------------------------------------------------------
   // session state and event logic
   // ------------------------------------------------------------------
   logic            in_program_ff,   in_program_in;
   logic [7:0]      last_track_ff,   last_track_in;
   logic [7:0]      last_rel_min_ff, last_rel_min_in;
   logic [7:0]      last_rel_sec_ff, last_rel_sec_in;
   logic [7:0]      last_abs_min_ff, last_abs_min_in;
   logic [7:0]      last_abs_sec_ff, last_abs_sec_in;
   logic [8:0]      repeat_count_ff, repeat_count_in;
   logic [15:0]     jumps_ff,        jumps_in;
   logic [15:0]     stucks_ff,       stucks_in;
   logic            produce;
   logic            time_moved;
   logic            jump;
   cdstm_event_type ev;

   // a lead frame outside a session is dropped like a bad frame
   assign produce    = frame.good && (!frame.lead || in_program_ff);
   assign time_moved = (frame.abs_min != last_abs_min_ff) ||
                       (frame.abs_sec != last_abs_sec_ff);

   // one-second step, with minute carry after second 59
   always_comb begin
      if (last_abs_sec_ff == SecLast) begin
         jump = (frame.abs_sec != '0) ||
                (({1'b0, last_abs_min_ff} + 9'd1) != {1'b0, frame.abs_min});
      end else begin
         jump = ({1'b0, last_abs_sec_ff} + 9'd1) != {1'b0, frame.abs_sec};
      end
   end

   always_comb begin
      in_program_in   = in_program_ff;
      last_track_in   = last_track_ff;
      last_rel_min_in = last_rel_min_ff;
      last_rel_sec_in = last_rel_sec_ff;
      last_abs_min_in = last_abs_min_ff;
      last_abs_sec_in = last_abs_sec_ff;
      repeat_count_in = repeat_count_ff;
      jumps_in        = jumps_ff;
      stucks_in       = stucks_ff;
      ev              = EvRepeat;

      if (frame.lead) begin
         // session end: report, then clear everything
         ev              = EvSessionEnd;
         in_program_in   = 1'b0;
         last_track_in   = '0;
         last_rel_min_in = '0;
         last_rel_sec_in = '0;
         last_abs_min_in = '0;
         last_abs_sec_in = '0;
         repeat_count_in = '0;
         jumps_in        = '0;
         stucks_in       = '0;
      end else begin
         in_program_in = 1'b1;
         if (time_moved) begin
            ev = jump ? EvJump : EvAdvance;
            if (jump && (jumps_ff != CntMax)) begin
               jumps_in = jumps_ff + 16'd1;
            end
            last_track_in   = frame.track;
            last_rel_min_in = frame.rel_min;
            last_rel_sec_in = frame.rel_sec;
            last_abs_min_in = frame.abs_min;
            last_abs_sec_in = frame.abs_sec;
            repeat_count_in = '0;
         end else if (repeat_count_ff <= {1'b0, stuck_limit_ff}) begin
            // count repeats up to limit+1, stuck reported once on reaching it
            repeat_count_in = repeat_count_ff + 9'd1;
            if (repeat_count_ff == {1'b0, stuck_limit_ff}) begin
               ev = EvStuck;
               if (stucks_ff != CntMax) begin
                  stucks_in = stucks_ff + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_program_ff   <= 1'b0;
         last_track_ff   <= '0;
         last_rel_min_ff <= '0;
         last_rel_sec_ff <= '0;
         last_abs_min_ff <= '0;
         last_abs_sec_ff <= '0;
         repeat_count_ff <= '0;
         jumps_ff        <= '0;
         stucks_ff       <= '0;
      end else if (advance && produce) begin
         in_program_ff   <= in_program_in;
         last_track_ff   <= last_track_in;
         last_rel_min_ff <= last_rel_min_in;
         last_rel_sec_ff <= last_rel_sec_in;
         last_abs_min_ff <= last_abs_min_in;
         last_abs_sec_ff <= last_abs_sec_in;
         repeat_count_ff <= repeat_count_in;
         jumps_ff        <= jumps_in;
         stucks_ff       <= stucks_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic            rsp_valid_ff, rsp_valid_in;
   cdstm_event_type rsp_event_ff;
   logic [7:0]      rsp_track_ff;
   logic [7:0]      rsp_rel_min_ff;
   logic [7:0]      rsp_rel_sec_ff;
   logic [7:0]      rsp_prev_track_ff;
   logic [7:0]      rsp_prev_min_ff;
   logic [7:0]      rsp_prev_sec_ff;
   logic [15:0]     rsp_jump_count_ff;
   logic [15:0]     rsp_stuck_count_ff;

   assign rsp_valid_in = out_free ? (advance && produce) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // counts show the state after this frame, before any session clear
   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_event_ff       <= ev;
         rsp_track_ff       <= frame.track;
         rsp_rel_min_ff     <= frame.rel_min;
         rsp_rel_sec_ff     <= frame.rel_sec;
         rsp_prev_track_ff  <= last_track_ff;
         rsp_prev_min_ff    <= last_rel_min_ff;
         rsp_prev_sec_ff    <= last_rel_sec_ff;
         rsp_jump_count_ff  <= frame.lead ? jumps_ff : jumps_in;
         rsp_stuck_count_ff <= frame.lead ? stucks_ff : stucks_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_res   = rsp_event_ff;
   assign rsp.track       = rsp_track_ff;
   assign rsp.rel_min     = rsp_rel_min_ff;
   assign rsp.rel_sec     = rsp_rel_sec_ff;
   assign rsp.prev_track  = rsp_prev_track_ff;
   assign rsp.prev_min    = rsp_prev_min_ff;
   assign rsp.prev_sec    = rsp_prev_sec_ff;
   assign rsp.jump_count  = rsp_jump_count_ff;
   assign rsp.stuck_count = rsp_stuck_count_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   logic frame_taken;
   logic session_idle;

   assign frame_taken  = advance && produce;
   assign session_idle = !in_program_ff && (jumps_ff == '0) && (stucks_ff == '0);

   // a held frame in the input register is never lost
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   // a session end leaves the session cleared
   `ASSERT_NEXT(a_end_clear, clock, reset, frame_taken && frame.lead, session_idle)
   // every frame that produces a result fills the result register
   `ASSERT_NEXT(a_rsp_follows, clock, reset, frame_taken, rsp_valid_ff)
   // a program frame opens or keeps the session
   `ASSERT_NEXT(a_in_session, clock, reset, frame_taken && !frame.lead, in_program_ff)

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the subcode time monitor: q frames go in over a
// valid/ready channel, a mirror of the session state predicts every result
// beat, and a checker compares the results field by field in order
// ----------------------------------------------------------------------------
module tb_top;
   import cdstm_pkg::*;

   localparam int          ClockPeriod    = 20;
   localparam int          ResetCycles    = 5;
   localparam int          SettleCycles   = 4;      // two-stage pipe plus margin
   localparam int          LongHoldCycles = 400;
   localparam int          PhaseFrames    = 150;
   localparam int          NumPhases      = 6;
   localparam int          DrainLimit     = 2000;
   localparam longint      TimeoutCycles  = 1_000_000;

   // one q frame as it sits on the request channel
   typedef struct packed {
      logic        crc_ok;
      logic [31:0] q_word0;
      logic [31:0] q_word1;
      logic [15:0] q_word2_high;
   } q_frame_type;

   // one result beat
   typedef struct packed {
      cdstm_event_type evt;
      logic [7:0]      track;
      logic [7:0]      rel_min;
      logic [7:0]      rel_sec;
      logic [7:0]      prev_track;
      logic [7:0]      prev_min;
      logic [7:0]      prev_sec;
      logic [15:0]     jump_count;
      logic [15:0]     stuck_count;
   } time_report_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   cdstm_req_if req_ch ();
   cdstm_rsp_if rsp_ch ();

   cd_subcode_time_monitor i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // frames waiting to be offered, and result beats still owed by the block
   q_frame_type     frame_backlog[$];
   time_report_type pending_reports[$];
   int unsigned     n_errors;

   // idling controls shared between the stimulus thread and the two sides
   bit           src_gaps_on;
   bit           snk_gaps_on;
   bit           long_hold_ask;

   // mirror of the block's session state and its one register
   logic         mir_in_program;
   logic [7:0]   mir_track;
   logic [7:0]   mir_rel_min;
   logic [7:0]   mir_rel_sec;
   logic [7:0]   mir_abs_min;
   logic [7:0]   mir_abs_sec;
   logic [8:0]   mir_repeats;
   logic [15:0]  mir_jumps;
   logic [15:0]  mir_stucks;
   logic [7:0]   mir_stuck_limit;

   // each bcd digit travels with its bits reversed inside the nibble;
   // the swap is its own inverse, so it serves for encoding and decoding
   function automatic logic [7:0] flip_nibbles(input logic [7:0] b);
      return {b[4], b[5], b[6], b[7], b[0], b[1], b[2], b[3]};
   endfunction

   // tens*10 + ones, no range check: 0xff reads as 165
   function automatic logic [7:0] bcd_value(input logic [7:0] code);
      return 8'(code[7:4]) * 8'd10 + 8'(code[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic void clear_mirror();
      mir_in_program = 1'b0;
      mir_track      = '0;
      mir_rel_min    = '0;
      mir_rel_sec    = '0;
      mir_abs_min    = '0;
      mir_abs_sec    = '0;
      mir_repeats    = '0;
      mir_jumps      = '0;
      mir_stucks     = '0;
   endfunction

   // advances the mirror by one accepted frame and queues the beat it owes
   function automatic void follow_q_frame(input q_frame_type f);
      logic [7:0]      adr_byte;
      logic [7:0]      trk_code;
      logic [7:0]      trk;
      logic [7:0]      rmin;
      logic [7:0]      rsec;
      logic [7:0]      amin;
      logic [7:0]      asec;
      logic            jumped;
      time_report_type rpt;
      adr_byte = flip_nibbles(f.q_word0[31:24]);
      // bad crc or not a mode 1 frame: silently dropped
      if (!f.crc_ok || adr_byte[3:0] != AdrMode1) return;
      trk_code = flip_nibbles(f.q_word0[23:16]);
      trk  = bcd_value(trk_code);
      rmin = bcd_value(flip_nibbles(f.q_word0[7:0]));
      rsec = bcd_value(flip_nibbles(f.q_word1[31:24]));
      amin = bcd_value(flip_nibbles(f.q_word1[7:0]));
      asec = bcd_value(flip_nibbles(f.q_word2_high[15:8]));
      rpt.track      = trk;
      rpt.rel_min    = rmin;
      rpt.rel_sec    = rsec;
      rpt.prev_track = mir_track;
      rpt.prev_min   = mir_rel_min;
      rpt.prev_sec   = mir_rel_sec;
      if (trk_code == TrackLeadIn || trk_code == TrackLeadOut) begin
         // lead frame outside a session is ignored
         if (!mir_in_program) return;
         rpt.evt         = EvSessionEnd;
         rpt.jump_count  = mir_jumps;
         rpt.stuck_count = mir_stucks;
         pending_reports.push_back(rpt);
         clear_mirror();
         return;
      end
      mir_in_program = 1'b1;
      if (amin != mir_abs_min || asec != mir_abs_sec) begin
         // new timestamp: anything but +1 second (with minute carry) is a jump
         if (mir_abs_sec == SecLast)
            jumped = (asec != 8'd0) || ({1'b0, mir_abs_min} + 9'd1 != {1'b0, amin});
         else
            jumped = ({1'b0, mir_abs_sec} + 9'd1 != {1'b0, asec});
         rpt.evt = EvAdvance;
         if (jumped) begin
            rpt.evt = EvJump;
            if (mir_jumps != CntMax) mir_jumps++;
         end
         mir_track   = trk;
         mir_rel_min = rmin;
         mir_rel_sec = rsec;
         mir_abs_min = amin;
         mir_abs_sec = asec;
         mir_repeats = '0;
      end else begin
         // same timestamp again: count up to limit+1, report stuck once there
         rpt.evt = EvRepeat;
         if (mir_repeats <= {1'b0, mir_stuck_limit}) begin
            mir_repeats++;
            if (mir_repeats == {1'b0, mir_stuck_limit} + 9'd1) begin
               rpt.evt = EvStuck;
               if (mir_stucks != CntMax) mir_stucks++;
            end
         end
      end
      rpt.jump_count  = mir_jumps;
      rpt.stuck_count = mir_stucks;
      pending_reports.push_back(rpt);
   endfunction

   function automatic int unsigned idle_draw(input bit on);
      return on ? $urandom_range(0, 12) : 0;
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // frame driver: offers the backlog one beat at a time, with a random gap
   // drawn per frame; the mirror steps on every accepted beat
   // ------------------------------------------------------------------------
   q_frame_type on_wire;
   int unsigned src_wait;

   always @(posedge clock) begin : drive_frames
      logic offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_wait = 0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            follow_q_frame(on_wire);
            offer = 1'b0;
         end
         if (!offer) begin
            if (src_wait != 0) begin
               src_wait--;
            end else if (frame_backlog.size() != 0) begin
               on_wire = frame_backlog.pop_front();
               req_ch.crc_ok       <= on_wire.crc_ok;
               req_ch.q_word0      <= on_wire.q_word0;
               req_ch.q_word1      <= on_wire.q_word1;
               req_ch.q_word2_high <= on_wire.q_word2_high;
               offer = 1'b1;
               src_wait = idle_draw(src_gaps_on);
            end
         end
         // single update of valid per edge, so back-to-back beats keep it high
         req_ch.valid <= offer;
      end
   end

   // ------------------------------------------------------------------------
   // result checker: takes beats with a random stall after each one, plus one
   // long hold-off on request so the pipe fills and backs up into req
   // ------------------------------------------------------------------------
   int unsigned snk_wait;
   int unsigned hold_left;

   always @(posedge clock) begin : check_reports
      time_report_type got;
      time_report_type want;
      logic            take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         snk_wait  = 0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.evt         = cdstm_event_type'(rsp_ch.event_res);
            got.track       = rsp_ch.track;
            got.rel_min     = rsp_ch.rel_min;
            got.rel_sec     = rsp_ch.rel_sec;
            got.prev_track  = rsp_ch.prev_track;
            got.prev_min    = rsp_ch.prev_min;
            got.prev_sec    = rsp_ch.prev_sec;
            got.jump_count  = rsp_ch.jump_count;
            got.stuck_count = rsp_ch.stuck_count;
            if (pending_reports.size() == 0) begin
               n_errors++;
               $display("%0t: result beat with nothing owed, expected none, got event %0d",
                        $time, got.evt);
            end else begin
               want = pending_reports.pop_front();
               compare_field("event_res",   want.evt,         got.evt);
               compare_field("track",       want.track,       got.track);
               compare_field("rel_min",     want.rel_min,     got.rel_min);
               compare_field("rel_sec",     want.rel_sec,     got.rel_sec);
               compare_field("prev_track",  want.prev_track,  got.prev_track);
               compare_field("prev_min",    want.prev_min,    got.prev_min);
               compare_field("prev_sec",    want.prev_sec,    got.prev_sec);
               compare_field("jump_count",  want.jump_count,  got.jump_count);
               compare_field("stuck_count", want.stuck_count, got.stuck_count);
            end
            snk_wait = idle_draw(snk_gaps_on);
         end
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end else if (long_hold_ask) begin
            long_hold_ask = 1'b0;
            hold_left = LongHoldCycles;
            take = 1'b0;
         end else if (snk_wait != 0) begin
            snk_wait--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_ch.ready <= take;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // fields are the decoded-order codes; control, index, frame, zero and
   // absolute frame bytes are always random
   task automatic push_frame(input bit crc, input logic [3:0] adr, input logic [7:0] trk,
                             input logic [7:0] rmin, input logic [7:0] rsec,
                             input logic [7:0] amin, input logic [7:0] asec);
      q_frame_type f;
      f.crc_ok       = crc;
      f.q_word0      = {flip_nibbles({4'($urandom), adr}), flip_nibbles(trk),
                        8'($urandom), flip_nibbles(rmin)};
      f.q_word1      = {flip_nibbles(rsec), 8'($urandom), 8'($urandom), flip_nibbles(amin)};
      f.q_word2_high = {flip_nibbles(asec), 8'($urandom)};
      frame_backlog.push_back(f);
   endtask

   // well-formed program frame at absolute am:as, random relative time
   task automatic push_program(input int unsigned trk, input int unsigned am,
                               input int unsigned as);
      push_frame(1'b1, AdrMode1, to_bcd(trk), to_bcd($urandom_range(0, 99)),
                 to_bcd($urandom_range(0, 59)), to_bcd(am), to_bcd(as));
   endtask

   task automatic push_lead(input bit lead_out);
      push_frame(1'b1, AdrMode1, lead_out ? TrackLeadOut : TrackLeadIn, 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_noise();
      logic [3:0] adr;
      case ($urandom_range(0, 2))
         0: begin
            push_frame(1'b0, AdrMode1, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
         end
         1: begin
            do adr = 4'($urandom); while (adr == AdrMode1);
            push_frame(1'b1, adr, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
         end
         default: begin
            // raw words, anything goes
            frame_backlog.push_back({1'($urandom), 32'($urandom), 32'($urandom),
                                     16'($urandom)});
         end
      endcase
   endtask

   // one session: mostly one-second steps with short repeat runs, some
   // jumps, occasional runs long enough to trip stuck, sprinkled noise,
   // closed by a lead frame
   task automatic play_session(input int unsigned budget, output int unsigned made);
      int unsigned am;
      int unsigned as;
      int unsigned trk;
      int unsigned reps;
      int unsigned pick;
      logic [7:0]  code;
      made = 0;
      trk  = $urandom_range(1, 99);
      if ($urandom_range(0, 2) != 0) begin
         // normal start around 00:01
         am = 0;
         as = $urandom_range(0, 2);
      end else begin
         am = $urandom_range(0, 98);
         as = $urandom_range(0, 59);
      end
      while (made < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            push_noise();
         end else if (pick < 16) begin
            // program frame with non-bcd codes everywhere
            do code = 8'($urandom); while (code == TrackLeadIn || code == TrackLeadOut);
            push_frame(1'b1, AdrMode1, code, 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
            made++;
         end else begin
            if (pick < 28) begin
               am = $urandom_range(0, 99);
               as = $urandom_range(0, 59);
            end else if (pick < 88) begin
               if (as == 59) begin
                  as = 0;
                  am = (am == 99) ? 0 : am + 1;
               end else begin
                  as++;
               end
            end
            if (pick >= 80 && pick < 85) trk = trk % 99 + 1;
            if ($urandom_range(0, 9) == 0)
               reps = mir_stuck_limit + $urandom_range(0, 2);
            else
               reps = $urandom_range(0, 3);
            repeat (reps + 1) push_program(trk, am, as);
            made += reps + 1;
         end
      end
      push_lead(1'($urandom));
      // now and then a second lead frame, which lands outside any session
      if ($urandom_range(0, 3) == 0) push_lead(1'($urandom));
   endtask

   // register write, only ever issued while the block is idle
   task automatic write_stuck_limit(input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'(4 * int'(RegStuckLimit));
      pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      mir_stuck_limit = value;
   endtask

   // sender holds back until every owed beat is in, then lets dropped
   // frames clear the pipe
   task automatic wait_quiet();
      @(negedge clock);
      while (frame_backlog.size() != 0 || req_ch.valid || pending_reports.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : run_all
      logic [7:0]  phase_limit[NumPhases];
      bit          phase_src_gaps[NumPhases];
      bit          phase_snk_gaps[NumPhases];
      int unsigned made;
      int unsigned total;
      int unsigned waited;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.crc_ok       = 1'b0;
      req_ch.q_word0      = '0;
      req_ch.q_word1      = '0;
      req_ch.q_word2_high = '0;
      rsp_ch.ready        = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      n_errors            = 0;
      long_hold_ask       = 1'b0;
      src_gaps_on         = 1'b1;
      snk_gaps_on         = 1'b1;
      clear_mirror();
      mir_stuck_limit = StuckLimitReset;

      phase_limit    = '{StuckLimitReset, 8'd0, 8'd1, 8'd255,
                         8'($urandom_range(3, 12)), 8'($urandom_range(1, 254))};
      phase_src_gaps = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      phase_snk_gaps = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // directed frames, stuck limit of 2
      write_stuck_limit(8'd2);
      push_frame(1'b0, AdrMode1, to_bcd(1), 8'h00, 8'h01, 8'h00, 8'h01); // bad crc
      push_frame(1'b1, 4'hf, to_bcd(1), 8'h00, 8'h01, 8'h00, 8'h01);     // wrong adr
      push_lead(1'b0);                         // lead-in outside a session
      push_lead(1'b1);                         // lead-out outside a session
      push_program(1, 0, 1);                   // clean start at 00:01
      push_program(1, 0, 2);
      repeat (4) push_program(1, 0, 2);        // repeats, stuck on the third, then hold
      push_program(2, 0, 59);                  // jump
      push_program(2, 1, 0);                   // minute carry
      push_program(2, 1, 2);                   // skipped second
      push_frame(1'b1, AdrMode1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);      // all-ones codes
      frame_backlog.push_back({1'b1, 32'h0, 32'h0, 16'h0});              // zero words, adr 0
      push_lead(1'b1);                         // session end with counts
      repeat (3) push_program(3, 0, 0);        // start at 00:00 matches reset time
      push_lead(1'b0);                         // session end by lead-in
      push_program(4, 5, 0);                   // start away from 00:01 is a jump
      push_lead(1'b1);
      frame_backlog.push_back({1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff});
      wait_quiet();

      // random phases over several stuck limits and idling mixes
      for (int p = 0; p < NumPhases; p++) begin
         write_stuck_limit(phase_limit[p]);
         src_gaps_on = phase_src_gaps[p];
         snk_gaps_on = phase_snk_gaps[p];
         total = 0;
         while (total < PhaseFrames) begin
            play_session($urandom_range(8, 60), made);
            total += made;
         end
         // receiver goes away while the backlog is still full
         if (p == 1) long_hold_ask = 1'b1;
         wait_quiet();
      end

      // wind down: everything offered, then owed beats, then a short tail
      while (frame_backlog.size() != 0 || req_ch.valid) @(negedge clock);
      waited = 0;
      while (pending_reports.size() != 0 && waited < DrainLimit) begin
         @(negedge clock);
         waited++;
      end
      repeat (SettleCycles) @(negedge clock);
      if (pending_reports.size() != 0) begin
         n_errors++;
         $display("%0t: %0d result beats missing, expected event %0d, got none",
                  $time, pending_reports.size(), pending_reports[0].evt);
      end
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(ClockPeriod * TimeoutCycles);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/cdstm_pkg.sv
rtl/cdstm_req_if.sv
rtl/cdstm_rsp_if.sv
rtl/cdstm_decode.sv
rtl/cd_subcode_time_monitor.sv
dv/tb_top.sv
